/* sv/lcgr_pkg.sv */
// Package for the ranged LCG random generator: constants, sequencer states,
// and the float-rounding helpers. No dependencies.
`timescale 1ns / 1ps
package lcgr_pkg;

    localparam logic [31:0] LCG_MUL   = 32'd214013;
    localparam logic [31:0] LCG_ADD   = 32'd2531011;
    localparam logic [31:0] RESET_STATE = 32'd1;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LCG,
        ST_SCALE,
        ST_ADD,
        ST_DONE
    } lcgr_state_t;

    // Round a 32-bit unsigned integer to binary32 (RNE), returned as a
    // 24-bit significand and the exponent shift (value = sig << sh).
    // sig is zero only for an input of zero.
    typedef struct packed {
        logic [24:0] sig;   // may be 2^24 after carry out of rounding
        logic [3:0]  sh;    // 0..8
    } lcgr_fp_t;

    function automatic lcgr_fp_t round_u32(input logic [31:0] v);
        lcgr_fp_t res;
        logic [3:0] sh;
        logic [31:0] rest;
        logic half;
        logic sticky;
        logic [24:0] q;
        sh = 4'd0;
        for (int i = 25; i <= 32; i++) begin
            if (v[i-1]) sh = 4'(i - 24);
        end
        q = 25'(v >> sh);
        rest = v & ((32'd1 << sh) - 32'd1);
        half = (sh != 4'd0) ? rest[sh - 4'd1] : 1'b0;
        sticky = (sh > 4'd1) ? ((rest & ((32'd1 << (sh - 4'd1)) - 32'd1)) != 32'd0) : 1'b0;
        if (half && (sticky || q[0])) q = q + 25'd1;
        res.sig = q;
        res.sh = sh;
        return res;
    endfunction

    // Round a fixed-point magnitude to 24 significant bits (RNE), keeping
    // the same scale; the result may carry into one more bit.
    function automatic logic [80:0] round_sig24(input logic [79:0] x);
        logic [6:0]  msb;
        logic [6:0]  cut;
        logic [79:0] q;
        logic [79:0] rem;
        logic        hb;
        logic        sb;
        logic [80:0] rq;
        msb = 7'd0;
        for (int i = 0; i < 80; i++)
            if (x[i]) msb = 7'(i);
        cut = (msb > 7'd23) ? (msb - 7'd23) : 7'd0;
        q = x >> cut;
        rem = x & ((80'd1 << cut) - 80'd1);
        hb = (cut != 7'd0) ? rem[cut - 7'd1] : 1'b0;
        sb = (cut > 7'd1) ? ((rem & ((80'd1 << (cut - 7'd1)) - 80'd1)) != 80'd0) : 1'b0;
        rq = 81'(q);
        if (hb && (sb || q[0])) rq = rq + 81'd1;
        return rq << cut;
    endfunction

endpackage

/* sv/lcgr_scale.sv */
// Scaling datapath for the ranged generator: one shared 32x32 multiplier
// used for the LCG update and the scale product, with a registered product.
// Depends on lcgr_pkg.
`timescale 1ns / 1ps
module lcgr_scale
    import lcgr_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] mul_a,
    input  logic [31:0] mul_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= mul_a * mul_b;
    end

    assign product = product_reg;

endmodule

/* sv/lcg_ranged_random_top.sv */
// Top level of the ranged LCG random generator: stream handshake, sequencer
// and float scaling. Depends on lcgr_pkg and lcgr_scale.
`timescale 1ns / 1ps
// A transaction on the input side either loads the 32-bit generator state or
// draws: the state steps as state*214013+2531011, r = state[30:16], and the
// result is trunc(r/32768 * float(max-min+1) + float(min)) in binary32 with
// round-to-nearest-even, saturating at 0xFFFFFFFF. Each input gives one
// output transaction carrying the value and the new state. A draw passes the
// states LCG (state update from the registered state product, scale multiply),
// SCALE (product rounding) and ADD (sum and rounding) to DONE, where its output
// is valid; a load goes from the accepting idle state straight to DONE. One shared
// 32x32 multiplier sets the pace.
// The block accepts nothing while an item is in work or its result waits.
module lcg_ranged_random_top
    import lcgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // min_value, max_value, new_state
    input  logic [0:0]  s_tuser,    // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata     // random_value, state_after
);

    lcgr_state_t st_reg, st_next;
    logic [31:0] gen_reg, gen_next;
    logic [31:0] min_reg, span_reg;
    logic [31:0] val_reg, val_next;
    logic [4:0]  rsh_reg;
    logic [39:0] scl_reg;
    logic [80:0] scl_rnd;
    logic [31:0] mul_a, mul_b;
    logic [63:0] product;
    lcgr_fp_t    span_fp, min_fp;

    logic        in_op;
    logic [31:0] in_min, in_max, in_ns;
    assign in_min = s_tdata[31:0];
    assign in_max = s_tdata[63:32];
    assign in_ns  = s_tdata[95:64];
    assign in_op  = s_tuser[0];

    lcgr_scale u_scale (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    assign span_fp = round_u32(span_reg);
    assign min_fp  = round_u32(min_reg);

    always_comb
    begin
        mul_a = gen_reg;
        mul_b = LCG_MUL;
        if (st_reg == ST_LCG)
        begin
            mul_a = {17'd0, gen_next[30:16]};
            mul_b = {7'd0, span_fp.sig};
        end
    end

    // Scaled term r * sig, rounded to float precision on its own before the
    // sum (r * sig < 2^39, so the rounded value fits 40 bits).
    assign scl_rnd = round_sig24(80'(product[39:0]));

    // Float sum of the rounded scaled term (scl * 2^(sh-15)) and float(min):
    // both as fixed point with 15 fraction bits, add, round to 24 bits.
    logic [79:0] s_fx;
    logic [80:0] rq;
    always_comb
    begin
        s_fx = (80'(scl_reg) << rsh_reg) + ((80'(min_fp.sig) << min_fp.sh) << 15);
        rq = round_sig24(s_fx);
        // drop the 15 fraction bits: truncation toward zero
        if (rq[80:47] != 34'd0) val_next = 32'hFFFF_FFFF;
        else                    val_next = rq[46:15];
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:  if (s_tvalid) st_next = (in_op == OP_LOAD) ? ST_DONE : ST_LCG;
            ST_LCG:   st_next = ST_SCALE;
            ST_SCALE: st_next = ST_ADD;
            ST_ADD:   st_next = ST_DONE;
            ST_DONE:  if (m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        gen_next = gen_reg;
        if (st_reg == ST_LCG) gen_next = product[31:0] + LCG_ADD;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = (st_reg == ST_DONE);
    assign m_tdata  = {gen_reg, val_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            gen_reg <= RESET_STATE;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_IDLE && s_tvalid && in_op == OP_LOAD) gen_reg <= in_ns;
            else gen_reg <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && s_tvalid)
        begin
            min_reg  <= in_min;
            span_reg <= in_max - in_min + 32'd1;
            val_reg  <= 32'd0;
        end
        if (st_reg == ST_LCG) rsh_reg <= 5'(span_fp.sh);
        if (st_reg == ST_SCALE) scl_reg <= scl_rnd[39:0];
        if (st_reg == ST_ADD) val_reg <= val_next;
    end

endmodule

/* tb/tb.sv */
// Self-checking bench for lcg_ranged_random_top: drives draw and load items on
// the input stream, predicts value and state in exact integer math.
// Depends on lcgr_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
    import lcgr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;   // min_value, max_value, new_state
    logic [0:0]   s_tuser;   // operation
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;   // random_value, state_after

    logic [31:0] gen_state;
    logic [31:0] want_value[$];
    logic [31:0] want_state[$];
    int          errors;
    int          cycles;
    bit          idle_on;

    lcg_ranged_random_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Round an integer to 24 significant bits, ties to even.
    function automatic logic [63:0] round24(input logic [63:0] x);
        int          msb;
        int          sh;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        msb = -1;
        for (int i = 0; i < 64; i++)
            if (x[i]) msb = i;
        if (msb < 24)
            return x;
        sh = msb - 23;
        q = x >> sh;
        rem = x & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q = q + 64'd1;
        return q << sh;
    endfunction

    // Scaled draw; all values held in units of 2^-15, which is exact here.
    function automatic logic [31:0] scale_draw(input logic [14:0] r,
                                               input logic [31:0] lo,
                                               input logic [31:0] hi);
        logic [31:0] span;
        logic [63:0] scaled;
        logic [63:0] sum;
        logic [63:0] whole;
        span = hi - lo + 32'd1;
        scaled = round24(64'(r) * round24(64'(span)));
        sum = round24(scaled + (round24(64'(lo)) << 15));
        whole = sum >> 15;
        if (whole >= 64'h1_0000_0000)
            return 32'hFFFF_FFFF;
        return whole[31:0];
    endfunction

    task automatic predict_item(input logic op, input logic [31:0] lo,
                                input logic [31:0] hi, input logic [31:0] ns);
        logic [31:0] value;
        value = 32'd0;
        if (op == OP_LOAD)
            gen_state = ns;
        else
        begin
            gen_state = gen_state * LCG_MUL + LCG_ADD;
            value = scale_draw(gen_state[30:16], lo, hi);
        end
        want_value.push_back(value);
        want_state.push_back(gen_state);
    endtask

    task automatic send_item(input logic op, input logic [31:0] lo,
                             input logic [31:0] hi, input logic [31:0] ns);
        s_tvalid <= 1'b1;
        s_tdata  <= {ns, hi, lo};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        predict_item(op, lo, hi, ns);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_draw(input logic [31:0] lo, input logic [31:0] hi);
        send_item(OP_DRAW, lo, hi, $urandom);
    endtask

    task automatic send_load(input logic [31:0] ns);
        send_item(OP_LOAD, $urandom, $urandom, ns);
    endtask

    // Output stall bursts.
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 4) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (want_value.size() == 0)
            begin
                $display("%0t: unexpected result value=%h state=%h",
                         $time, m_tdata[31:0], m_tdata[63:32]);
                errors++;
            end
            else
            begin
                logic [31:0] ev;
                logic [31:0] es;
                ev = want_value.pop_front();
                es = want_state.pop_front();
                if (m_tdata[31:0] !== ev)
                begin
                    $display("%0t: random_value expected %h actual %h",
                             $time, ev, m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== es)
                begin
                    $display("%0t: state_after expected %h actual %h",
                             $time, es, m_tdata[63:32]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic test_directed;
        send_draw(32'd0, 32'd99);               // first step from reset state
        send_draw(32'd0, 32'hFFFF_FFFF);        // full range wraps to zero span
        send_draw(32'd1, 32'd0);                // zero span, min kept
        send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF); // float(min) rounds to 2^32
        send_draw(32'hFFFF_FF00, 32'hFFFF_FFFF); // saturation near top
        send_draw(32'd0, 32'd0);
        send_draw(32'd100, 32'd5);              // inverted range
        send_draw(32'h8000_0000, 32'h7FFF_FFFF);
        send_load(32'd0);
        send_draw(32'd0, 32'd1000);
        send_load(32'hFFFF_FFFF);
        send_draw(32'h0100_0001, 32'h0200_0003); // rounding of odd bounds
        send_load(32'hAAAA_5555);
        send_draw(32'hFFFF_FFFE, 32'h0000_0001);
        send_item(OP_DRAW, 32'd7, 32'd7, 32'hFFFF_FFFF);
        send_item(OP_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678);
        send_draw(32'd10, 32'd20);
    endtask

    task automatic random_item;
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom;
        case ($urandom_range(0, 9))
            0:       send_load($urandom);
            1:       send_draw(lo, lo - 32'd1);
            2:       send_draw(32'hFFFF_FFFF - $urandom_range(0, 300), 32'hFFFF_FFFF);
            3:       send_draw(lo, $urandom);
            4:       send_draw(32'd0, $urandom);
            5, 6:
            begin
                lo = $urandom_range(0, 1000);
                send_draw(lo, lo + $urandom_range(0, 1000));
            end
            default:
            begin
                hi = lo + ($urandom >> $urandom_range(0, 31));
                send_draw(lo, hi);
            end
        endcase
    endtask

    task automatic test_random(input int n);
        repeat (n) random_item();
    endtask

    task automatic test_no_idle(input int n);
        idle_on = 1'b0;
        repeat (n) random_item();
    endtask

    initial
    begin
        errors   = 0;
        cycles   = 0;
        idle_on  = 1'b1;
        gen_state = RESET_STATE;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1600);
        test_no_idle(250);
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (want_value.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* filelist.f */
sv/lcgr_pkg.sv
sv/lcgr_scale.sv
sv/lcg_ranged_random_top.sv
tb/tb.sv
